>>> hdl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies property in the same cycle
`define FCM_ASSERT_NOW(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("assertion failed");

// condition implies property in the next cycle
`define FCM_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> hdl/fcm_pkg.sv
// types and constants of the frame check block
`timescale 1ns / 1ps

package fcm_pkg;

   typedef enum logic [1:0] {
      MODE_SUM16 = 2'd0,
      MODE_XOR8  = 2'd1,
      MODE_CRC16 = 2'd2,
      MODE_CRC8  = 2'd3
   } mode_type;

   // register index decode: word address bit of paddr
   localparam logic REG_CHECK_MODE = 1'b0;

   localparam logic [15:0] CRC16_POLY  = 16'hA001;
   localparam logic [15:0] CRC16_START = 16'hFFFF;
   localparam logic [7:0]  CRC8_POLY   = 8'h13;
   localparam logic [7:0]  CRC8_START  = 8'hFF;

   typedef struct packed {
      mode_type mode;
      logic     frame_start;
   } fold_ctl_type;

endpackage

>>> hdl/fcm_fold.sv
// one-byte fold of the running check for all four modes
`timescale 1ns / 1ps

module fcm_fold
   import fcm_pkg::*;
(
   input  fold_ctl_type ctl,
   input  logic [15:0]  running,
   input  logic [7:0]   data_byte,
   output logic [15:0]  next_check,
   output logic [15:0]  result_value
);

   logic [15:0] base;
   logic [15:0] crc16;
   logic [7:0]  crc8;

   // start value on the first byte of a frame
   always_comb begin
      base = running;
      if (ctl.frame_start) begin
         case (ctl.mode)
            MODE_CRC16: base = CRC16_START;
            MODE_CRC8:  base = {8'h00, CRC8_START};
            default:    base = 16'h0000;
         endcase
      end
   end

   // bitwise reflected crc updates, eight shifts each
   always_comb begin
      crc16 = base ^ {8'h00, data_byte};
      crc8  = base[7:0] ^ data_byte;
      for (int k = 0; k < 8; k++) begin
         if (crc16[0]) begin
            crc16 = (crc16 >> 1) ^ CRC16_POLY;
         end else begin
            crc16 = crc16 >> 1;
         end
         if (crc8[0]) begin
            crc8 = (crc8 >> 1) ^ CRC8_POLY;
         end else begin
            crc8 = crc8 >> 1;
         end
      end
   end

   always_comb begin
      case (ctl.mode)
         MODE_SUM16: next_check = base + {8'h00, data_byte};
         MODE_XOR8:  next_check = {8'h00, base[7:0] ^ data_byte};
         MODE_CRC16: next_check = crc16;
         MODE_CRC8:  next_check = {8'h00, crc8};
         default:    next_check = crc16;
      endcase
   end

   // 8-bit modes already hold zero in the upper byte
   assign result_value = next_check;

endmodule

>>> hdl/frame_check_multi_mode.sv
// top level of the multi-mode frame check generator
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_data_byte[7:0], req_last_byte
//   rsp      out        rsp_valid/rsp_ready  rsp_check_value[15:0]
//   csr      in/out     psel/penable/pready  paddr[2:0], pwdata/prdata[31:0]
//
// one word per cycle unless a held result stalls a last word; the fold is a single
// combinational pass from the input register into the running check and result register
// reset clears the valid flags, the frame flag and sets the mode to crc16 modbus
// a held result stalls the last word of a frame and the words behind it; earlier words flow
`timescale 1ns / 1ps

module frame_check_multi_mode
   import fcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // word input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // check result
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_check_value,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

`include "assert_macros.svh"

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_data_ff, s1_data_in;
   logic        s1_last_ff, s1_last_in;

   // running state
   logic [15:0] running_ff, running_in;
   logic        inside_frame_ff, inside_frame_in;
   mode_type    mode_ff, mode_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_value_ff, out_value_in;

   logic         out_free;
   logic         s1_adv;
   logic         req_take;
   logic         csr_write;
   fold_ctl_type fold_ctl;
   logic [15:0]  fold_next;
   logic [15:0]  fold_result;

   // a non-last word never needs the result register
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_take  = req_valid && req_ready;

   assign fold_ctl.mode        = mode_ff;
   assign fold_ctl.frame_start = !inside_frame_ff;

   fcm_fold u_fold (
      .ctl          (fold_ctl),
      .running      (running_ff),
      .data_byte    (s1_data_ff),
      .next_check   (fold_next),
      .result_value (fold_result)
   );

   // register port, no wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_CHECK_MODE);
   assign prdata    = (paddr[2] == REG_CHECK_MODE) ? {30'd0, mode_ff} : 32'd0;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write) begin
         mode_in = mode_type'(pwdata[1:0]);
      end
   end

   // input register load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_last_in  = s1_last_ff;
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data_byte;
         s1_last_in  = req_last_byte;
      end
   end

   // running check and frame tracking
   always_comb begin
      running_in      = running_ff;
      inside_frame_in = inside_frame_ff;
      if (s1_adv) begin
         running_in      = fold_next;
         inside_frame_in = !s1_last_ff;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_adv && s1_last_ff) begin
         out_valid_in = 1'b1;
         out_value_in = fold_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         inside_frame_ff <= 1'b0;
         running_ff      <= 16'h0000;
         mode_ff         <= MODE_CRC16;
         out_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         inside_frame_ff <= inside_frame_in;
         running_ff      <= running_in;
         mode_ff         <= mode_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      s1_last_ff   <= s1_last_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_check_value = out_value_ff;

   // last word closes the frame and fills the result register
   `FCM_ASSERT_NEXT(a_last_closes, s1_adv && s1_last_ff, out_valid_ff && !inside_frame_ff)
   // other words keep the frame open
   `FCM_ASSERT_NEXT(a_mid_opens, s1_adv && !s1_last_ff, inside_frame_ff)
   // a pending result is never overwritten by a last word
   `FCM_ASSERT_NOW(a_no_overrun, out_valid_ff && !rsp_ready && s1_valid_ff && s1_last_ff,
                   !s1_adv && !req_ready)
   // state after reset
   `FCM_ASSERT_NOW(a_reset_state, $past(reset),
                   !out_valid_ff && !inside_frame_ff && (mode_ff == MODE_CRC16))

endmodule
